// ===== hdl/euler_angles_to_basis_vectors_assert.svh =====
// Assertion macros used by the block's RTL.
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_ASSERT_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_ASSERT_SVH
`ifndef ASSERT_OFF
`define EAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define EAB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define EAB_ASSERT_IMP(lbl, ante, cons, msg)
`define EAB_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/eab_pkg.sv =====
`timescale 1ns / 1ps
package eab_pkg;
  localparam int ANGLE_BITS    = 16;
  localparam int OUT_FRAC_BITS = 14;
  localparam int OUT_W         = OUT_FRAC_BITS + 2;
  localparam int STEPS         = 30;
  localparam int ZW            = 34;
  localparam int VW            = 32;
  localparam int SW            = 34;
  localparam int RS            = 30 - OUT_FRAC_BITS;
  localparam logic signed [ZW-1:0] GAIN = 34'sd652032874;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] roll_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] forward_x;
    logic signed [OUT_W-1:0] forward_y;
    logic signed [OUT_W-1:0] forward_z;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] right_y;
    logic signed [OUT_W-1:0] right_z;
    logic signed [OUT_W-1:0] up_x;
    logic signed [OUT_W-1:0] up_y;
    logic signed [OUT_W-1:0] up_z;
  } out_item_t;

  function automatic logic signed [ZW-1:0] atan_at(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;   10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;   13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;    16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;     19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;      22: r = 34'sd163;       23: r = 34'sd81;
      24: r = 34'sd41;       25: r = 34'sd20;        26: r = 34'sd10;
      27: r = 34'sd5;        28: r = 34'sd3;         29: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [VW-1:0] qmul(input logic signed [VW-1:0] a,
                                                input logic signed [VW-1:0] b);
    logic signed [2*VW-1:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[VW+29:30];
  endfunction

  function automatic logic signed [OUT_W-1:0] to_out(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    logic signed [SW-1:0] r;
    logic signed [SW-1:0] lim;
    lim = SW'(1) <<< OUT_FRAC_BITS;
    t = (RS > 0) ? v + (SW'(1) <<< (RS > 0 ? RS - 1 : 0)) : v;
    r = t >>> RS;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[OUT_W-1:0];
  endfunction
endpackage

// ===== hdl/eab_if.sv =====
`timescale 1ns / 1ps
interface eab_in_if import eab_pkg::*; (input logic clk);
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eab_out_if import eab_pkg::*; (input logic clk);
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/euler_angles_to_basis_vectors.sv =====
`timescale 1ns / 1ps
// Euler angles to basis vectors: one transaction of pitch, yaw and roll (binary angles,
// one full turn per 2^16 units) gives forward, right and up in signed Q1.14, saturated
// to +-1. An input register, a 30-stage pipelined CORDIC per angle, two multiply stages
// and a rounding stage make 34 register stages between an accepted transaction and its
// result. One transaction is accepted per cycle unless the output stalls, and the whole
// pipeline holds while a finished result waits at the output.
`include "euler_angles_to_basis_vectors_assert.svh"
module euler_angles_to_basis_vectors import eab_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  eab_in_if.sink    in_ch,
  eab_out_if.source out_ch
);
  logic signed [ZW-1:0] x_r [0:STEPS][0:2];
  logic signed [ZW-1:0] y_r [0:STEPS][0:2];
  logic signed [ZW-1:0] z_r [0:STEPS][0:2];
  logic                 f_r [0:STEPS][0:2];
  logic [STEPS:0]       v_r;
  logic                 adv;
  logic signed [ANGLE_BITS-1:0] ang [0:2];

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;
  assign ang[0] = in_ch.data.pitch_angle;
  assign ang[1] = in_ch.data.yaw_angle;
  assign ang[2] = in_ch.data.roll_angle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[STEPS-1:0], in_ch.valid};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_ang
    logic [31:0] a;
    logic        fl;
    assign a  = {ang[k], {(32-ANGLE_BITS){1'b0}}};
    assign fl = a[31] ^ a[30];
    always_ff @(posedge clk) begin
      if (adv) begin
        x_r[0][k] <= GAIN;
        y_r[0][k] <= '0;
        z_r[0][k] <= ZW'(signed'({a[31] ^ fl, a[30:0]}));
        f_r[0][k] <= fl;
      end
    end
    for (genvar i = 0; i < STEPS; i++) begin : g_step
      logic signed [ZW-1:0] dx, dy;
      assign dx = y_r[i][k] >>> i;
      assign dy = x_r[i][k] >>> i;
      always_ff @(posedge clk) begin
        if (adv) begin
          f_r[i+1][k] <= f_r[i][k];
          if (!z_r[i][k][ZW-1]) begin
            x_r[i+1][k] <= x_r[i][k] - dx;
            y_r[i+1][k] <= y_r[i][k] + dy;
            z_r[i+1][k] <= z_r[i][k] - atan_at(i);
          end else begin
            x_r[i+1][k] <= x_r[i][k] + dx;
            y_r[i+1][k] <= y_r[i][k] - dy;
            z_r[i+1][k] <= z_r[i][k] + atan_at(i);
          end
        end
      end
    end
  end

  logic signed [VW-1:0] s_w [0:2];
  logic signed [VW-1:0] c_w [0:2];
  for (genvar k = 0; k < 3; k++) begin : g_sc
    assign s_w[k] = f_r[STEPS][k] ? -y_r[STEPS][k][VW-1:0] : y_r[STEPS][k][VW-1:0];
    assign c_w[k] = f_r[STEPS][k] ? -x_r[STEPS][k][VW-1:0] : x_r[STEPS][k][VW-1:0];
  end

  logic signed [VW-1:0] srsp_r, crsp_r, cpcy_r, cpsy_r, crsy_r, crcy_r;
  logic signed [VW-1:0] srsy_r, srcy_r, srcp_r, crcp_r, nsp_r, sy_r, cy_r;
  logic                 m1v_r, m2v_r, out_valid_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      srsp_r <= qmul(s_w[2], s_w[0]);
      crsp_r <= qmul(c_w[2], s_w[0]);
      cpcy_r <= qmul(c_w[0], c_w[1]);
      cpsy_r <= qmul(c_w[0], s_w[1]);
      crsy_r <= qmul(c_w[2], s_w[1]);
      crcy_r <= qmul(c_w[2], c_w[1]);
      srsy_r <= qmul(s_w[2], s_w[1]);
      srcy_r <= qmul(s_w[2], c_w[1]);
      srcp_r <= qmul(s_w[2], c_w[0]);
      crcp_r <= qmul(c_w[2], c_w[0]);
      nsp_r  <= -s_w[0];
      sy_r   <= s_w[1];
      cy_r   <= c_w[1];
    end
  end

  logic signed [VW-1:0] a2_r, b2_r, c2_r, d2_r;
  logic signed [VW-1:0] fx2_r, fy2_r, fz2_r, crsy2_r, crcy2_r, srsy2_r, srcy2_r;
  logic signed [VW-1:0] srcp2_r, crcp2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      a2_r    <= qmul(srsp_r, cy_r);
      b2_r    <= qmul(srsp_r, sy_r);
      c2_r    <= qmul(crsp_r, cy_r);
      d2_r    <= qmul(crsp_r, sy_r);
      fx2_r   <= cpcy_r;
      fy2_r   <= cpsy_r;
      fz2_r   <= nsp_r;
      crsy2_r <= crsy_r;
      crcy2_r <= crcy_r;
      srsy2_r <= srsy_r;
      srcy2_r <= srcy_r;
      srcp2_r <= srcp_r;
      crcp2_r <= crcp_r;
    end
  end

  out_item_t out_data_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.forward_x <= to_out(SW'(fx2_r));
      out_data_r.forward_y <= to_out(SW'(fy2_r));
      out_data_r.forward_z <= to_out(SW'(fz2_r));
      out_data_r.right_x   <= to_out(SW'(crsy2_r) - SW'(a2_r));
      out_data_r.right_y   <= to_out(-SW'(b2_r) - SW'(crcy2_r));
      out_data_r.right_z   <= to_out(-SW'(srcp2_r));
      out_data_r.up_x      <= to_out(SW'(c2_r) + SW'(srsy2_r));
      out_data_r.up_y      <= to_out(SW'(d2_r) - SW'(srcy2_r));
      out_data_r.up_z      <= to_out(SW'(crcp2_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1v_r       <= 1'b0;
      m2v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      m1v_r       <= v_r[STEPS];
      m2v_r       <= m1v_r;
      out_valid_r <= m2v_r;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  `EAB_ASSERT_NXT(a_hold, !adv, $stable(v_r) && $stable(m2v_r), "pipeline moved while stalled")
  `EAB_ASSERT_NXT(a_adv, adv && in_ch.valid, v_r[0], "accepted transaction lost")
  `EAB_ASSERT_IMP(a_range, out_valid_r,
    out_data_r.forward_z <= 16'sd16384 && out_data_r.forward_z >= -16'sd16384,
    "forward_z out of range")
endmodule
